>>> design/keyed_record_table_macros.svh
// Assertion macros for the keyed record table top level.
`ifndef KEYED_RECORD_TABLE_MACROS_SVH
`define KEYED_RECORD_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk_i, idle while rst_ni is low.
`define KRT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyed_record_table: check failed");
// Next-cycle implication, checked on clk_i, idle while rst_ni is low.
`define KRT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyed_record_table: check failed");
`else
`define KRT_ASSERT_IMP(name, ante, cons)
`define KRT_ASSERT_NXT(name, ante, cons)
`endif

`endif

>>> design/krt_pkg.sv
// Shared types and constants of the keyed record table.
`default_nettype none

package krt_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned NAME_BYTES = 8;

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned NAME_W = 64;
  localparam int unsigned PRIO_W = 8;

  // Request queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_CHANGE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_DUP       = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_RESP
  } back_state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name;
    logic [PRIO_W-1:0] prio;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  typedef struct packed {
    kind_e             kind;
    logic [KEY_W-1:0]  key_id;
    logic [NAME_W-1:0] name;
    logic [PRIO_W-1:0] prio;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic              clash_id;
    logic              clash_name;
    logic              clash_priority;
    logic [NAME_W-1:0] found_name;
    logic [PRIO_W-1:0] found_priority;
  } resp_t;

endpackage

`default_nettype wire

>>> design/krt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module krt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/krt_front.sv
// Front end: takes requests, normalizes the name and queues them for the back end.
`default_nettype none

module krt_front import krt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_vld_i,
  output logic                      in_rdy_o,
  input  wire logic [1:0]           in_kind_i,
  input  wire logic [IN_DATA_W-1:0] in_data_i,
  output logic                      req_vld_o,
  input  wire logic                 req_rdy_i,
  output req_t                      req_o
);

  req_t              q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;
  logic [NAME_W-1:0] raw_name, norm_name;
  logic              stop;
  req_t              req_in;

  // Keep bytes up to the first zero byte, clear the rest
  always_comb begin
    stop      = 1'b0;
    norm_name = '0;
    raw_name  = in_data_i[KEY_W +: NAME_W];
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (raw_name[8*k +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        norm_name[8*k +: 8] = raw_name[8*k +: 8];
      end
    end
  end

  always_comb begin
    req_in.kind   = kind_e'(in_kind_i);
    req_in.key_id = in_data_i[KEY_W-1:0];
    req_in.name   = norm_name;
    req_in.prio   = in_data_i[KEY_W+NAME_W +: PRIO_W];
  end

  assign in_rdy_o  = (cnt_q != QCNT_W'(QDEPTH));
  assign req_vld_o = (cnt_q != '0);
  assign req_o     = q_mem_q[rd_ptr_q];
  assign push      = in_vld_i && in_rdy_o;
  assign pop       = req_vld_o && req_rdy_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= req_in;
    end
  end

endmodule

`default_nettype wire

>>> design/krt_back.sv
// Back end: scans the record RAM one slot a cycle, applies the request, registers the response.
`default_nettype none

module krt_back import krt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  req_vld_i,
  output logic       req_rdy_o,
  input  req_t       req_i,
  output logic       out_vld_o,
  input  wire logic  out_rdy_i,
  output resp_t      out_resp_o
);

  back_state_e       state_q, state_d;
  req_t              req_q;
  logic [IDX_W-1:0]  cnt_q;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic [ENTRIES-1:0] valid_q;
  logic              clash_id_q, clash_name_q, clash_prio_q;
  logic              hit_q, free_q;
  logic [IDX_W-1:0]  hit_idx_q, free_idx_q;
  rec_t              hit_rec_q;
  logic              out_vld_q;
  resp_t             out_q;

  logic              take, fire, last_issue;
  rec_t              rd_rec;
  logic              ram_re, ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  rec_t              ram_wdata;
  resp_t             resp_d;
  logic              set_valid, clr_valid;
  logic [IDX_W-1:0]  valid_idx;

  assign req_rdy_o  = (state_q == BK_IDLE);
  assign take       = req_vld_i && req_rdy_o;
  assign fire       = (state_q == BK_RESP) && (!out_vld_q || out_rdy_i);
  assign last_issue = (cnt_q == IDX_W'(ENTRIES - 1));
  assign ram_re     = (state_q == BK_SCAN);

  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q),
    .rdata_o (rd_rec)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:  if (req_vld_i) state_d = BK_SCAN;
      BK_SCAN:  if (last_issue) state_d = BK_DRAIN;
      BK_DRAIN: state_d = BK_RESP;
      BK_RESP:  if (!out_vld_q || out_rdy_i) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Response and table update for the finished scan
  always_comb begin
    resp_d                = '0;
    ram_we                = 1'b0;
    ram_waddr             = free_idx_q;
    ram_wdata             = '{key: req_q.key_id, name: req_q.name, prio: req_q.prio};
    set_valid             = 1'b0;
    clr_valid             = 1'b0;
    valid_idx             = hit_idx_q;
    resp_d.status         = STAT_DONE;
    case (req_q.kind)
      KIND_INSERT: begin
        if (clash_id_q || clash_name_q || clash_prio_q) begin
          resp_d.status         = STAT_DUP;
          resp_d.clash_id       = clash_id_q;
          resp_d.clash_name     = clash_name_q;
          resp_d.clash_priority = clash_prio_q;
        end else if (!free_q) begin
          resp_d.status = STAT_FULL;
        end else begin
          ram_we    = fire;
          set_valid = fire;
          valid_idx = free_idx_q;
        end
      end
      KIND_LOOKUP: begin
        if (!hit_q) begin
          resp_d.status = STAT_NOT_FOUND;
        end else begin
          resp_d.found_name     = hit_rec_q.name;
          resp_d.found_priority = hit_rec_q.prio;
        end
      end
      KIND_DELETE: begin
        if (!hit_q) begin
          resp_d.status = STAT_NOT_FOUND;
        end else begin
          clr_valid = fire;
        end
      end
      KIND_CHANGE: begin
        if (!hit_q) begin
          resp_d.status = STAT_NOT_FOUND;
        end else begin
          ram_we    = fire;
          ram_waddr = hit_idx_q;
          ram_wdata = '{key: hit_rec_q.key, name: hit_rec_q.name, prio: req_q.prio};
        end
      end
      default: resp_d.status = STAT_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      valid_q      <= '0;
      clash_id_q   <= 1'b0;
      clash_name_q <= 1'b0;
      clash_prio_q <= 1'b0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      free_q       <= 1'b0;
      free_idx_q   <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == BK_SCAN);
      cmp_idx_q <= cnt_q;
      if (take) begin
        cnt_q        <= '0;
        clash_id_q   <= 1'b0;
        clash_name_q <= 1'b0;
        clash_prio_q <= 1'b0;
        hit_q        <= 1'b0;
        free_q       <= 1'b0;
      end else if (state_q == BK_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
      end
      // Fold one returned slot into the running result
      if (cmp_vld_q) begin
        if (valid_q[cmp_idx_q]) begin
          if (rd_rec.key == req_q.key_id) begin
            clash_id_q <= 1'b1;
            if (!hit_q) begin
              hit_q     <= 1'b1;
              hit_idx_q <= cmp_idx_q;
            end
          end
          if (rd_rec.name == req_q.name) clash_name_q <= 1'b1;
          if (rd_rec.prio == req_q.prio) clash_prio_q <= 1'b1;
        end else if (!free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end
      if (set_valid) valid_q[valid_idx] <= 1'b1;
      if (clr_valid) valid_q[valid_idx] <= 1'b0;
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= req_i;
    end
    if (cmp_vld_q && valid_q[cmp_idx_q] && !hit_q && rd_rec.key == req_q.key_id) begin
      hit_rec_q <= rd_rec;
    end
    if (fire) begin
      out_q <= resp_d;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_resp_o = out_q;

endmodule

`default_nettype wire

>>> design/keyed_record_table.sv
// Each request passes the two-deep request queue; the back end then scans every slot of the
// record RAM, drains the last read and registers its response.
// The back end takes a new request only after the last one's response is registered; the scan of
// the record RAM through its single read port, one slot per cycle, sets the pace; the two-deep
// request queue and the response register let input and output stall independently.
// Reset: valid bits, request queue and response register are cleared; no clearing pass.
`default_nettype none
`include "keyed_record_table_macros.svh"

module keyed_record_table import krt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // key_id[15:0], rec_name[79:16], rec_priority[87:80]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // clash_id[0], clash_name[1], clash_priority[2], found_name[66:3],
  // found_priority[74:67], zero[79:75]
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic      [1:0]            m_axis_tuser
);

  logic  req_vld, req_rdy;
  req_t  req;
  resp_t resp;

  krt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s_axis_tvalid),
    .in_rdy_o  (s_axis_tready),
    .in_kind_i (s_axis_tuser),
    .in_data_i (s_axis_tdata),
    .req_vld_o (req_vld),
    .req_rdy_i (req_rdy),
    .req_o     (req)
  );

  krt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_vld_i  (req_vld),
    .req_rdy_o  (req_rdy),
    .req_i      (req),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_resp_o (resp)
  );

  assign m_axis_tuser = resp.status;
  assign m_axis_tdata = {5'b00000, resp.found_priority, resp.found_name,
                         resp.clash_priority, resp.clash_name, resp.clash_id};

  // Back end works on one request at a time
  `KRT_ASSERT_NXT(a_back_single, req_vld && req_rdy, !req_rdy)
  // A duplicate refusal names at least one clashing field
  `KRT_ASSERT_IMP(a_dup_flags, m_axis_tvalid && m_axis_tuser == STAT_DUP, m_axis_tdata[2:0] != 3'b000)
  // Clash flags appear only with a duplicate refusal
  `KRT_ASSERT_IMP(a_flags_dup, m_axis_tvalid && m_axis_tuser != STAT_DUP, m_axis_tdata[2:0] == 3'b000)
  // Found fields stay zero unless the request succeeded
  `KRT_ASSERT_IMP(a_found_zero, m_axis_tvalid && m_axis_tuser != STAT_DONE, m_axis_tdata[74:3] == '0)

endmodule

`default_nettype wire

>>> tb/sv/keyed_record_table_checker.sv
// Response checker for the keyed record table: mirrors the table and compares every response.
`timescale 1ns / 1ps

module keyed_record_table_checker import krt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  // key_id[15:0], rec_name[79:16], rec_priority[87:80]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // clash_id[0], clash_name[1], clash_priority[2], found_name[66:3],
  // found_priority[74:67], zero[79:75]
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  input  wire logic [1:0]            m_axis_tuser,
  output int                         fail_count_o,
  output int                         pending_o
);

  // Mirror of the record table
  bit                slot_used  [ENTRIES];
  logic [KEY_W-1:0]  slot_key   [ENTRIES];
  logic [NAME_W-1:0] slot_name  [ENTRIES];
  logic [PRIO_W-1:0] slot_prio  [ENTRIES];

  resp_t awaited_resp_q[$];
  resp_t want;
  int    responses_seen = 0;

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    // Keep the log short when the block is badly off.
    if (fail_count_o <= 100) begin
      $display("%0t ns: response %0d: %s", $time, responses_seen, msg);
    end
  endtask

  task automatic check_field(input string field, input logic [NAME_W-1:0] got,
                             input logic [NAME_W-1:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s is %0h, should be %0h", field, got, exp_val));
    end
  endtask

  // Only the first NAME_BYTES bytes count, and the name stops at its first zero byte.
  function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] nm;
    bit                ended;
    nm    = '0;
    ended = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (raw[8*k +: 8] == 8'h00) ended = 1'b1;
      if (!ended) nm[8*k +: 8] = raw[8*k +: 8];
    end
    return nm;
  endfunction

  // Apply one request to the mirror and return the response it must produce.
  function automatic resp_t table_response(input kind_e kind, input logic [KEY_W-1:0] id,
                                           input logic [NAME_W-1:0] raw_name,
                                           input logic [PRIO_W-1:0] prio);
    resp_t             r;
    logic [NAME_W-1:0] nm;
    int                free_slot;
    int                hit;
    r         = '0;
    r.status  = STAT_DONE;
    nm        = trim_name(raw_name);
    free_slot = -1;
    hit       = -1;
    if (kind == KIND_INSERT) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i]) begin
          if (slot_key[i] == id)   r.clash_id       = 1'b1;
          if (slot_name[i] == nm)  r.clash_name     = 1'b1;
          if (slot_prio[i] == prio) r.clash_priority = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      // Clashes win over a full table.
      if (r.clash_id || r.clash_name || r.clash_priority) begin
        r.status = STAT_DUP;
      end else if (free_slot < 0) begin
        r.status = STAT_FULL;
      end else begin
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot]  = id;
        slot_name[free_slot] = nm;
        slot_prio[free_slot] = prio;
      end
    end else begin
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_key[i] == id) hit = i;
      end
      if (hit < 0) begin
        r.status = STAT_NOT_FOUND;
      end else begin
        case (kind)
          KIND_LOOKUP: begin
            r.found_name     = slot_name[hit];
            r.found_priority = slot_prio[hit];
          end
          KIND_DELETE: begin
            slot_used[hit] = 1'b0;
          end
          default: begin
            slot_prio[hit] = prio;
          end
        endcase
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      awaited_resp_q.delete();
      pending_o = 0;
    end else begin
      // Retire the response first: it can never belong to a request taken at this edge.
      if (m_axis_tvalid && m_axis_tready) begin
        responses_seen++;
        if (awaited_resp_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = awaited_resp_q.pop_front();
          check_field("status", NAME_W'(m_axis_tuser), NAME_W'(want.status));
          check_field("clash_id", NAME_W'(m_axis_tdata[0]), NAME_W'(want.clash_id));
          check_field("clash_name", NAME_W'(m_axis_tdata[1]), NAME_W'(want.clash_name));
          check_field("clash_priority", NAME_W'(m_axis_tdata[2]),
                      NAME_W'(want.clash_priority));
          check_field("found_name", m_axis_tdata[66:3], want.found_name);
          check_field("found_priority", NAME_W'(m_axis_tdata[74:67]),
                      NAME_W'(want.found_priority));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_resp_q.push_back(table_response(kind_e'(s_axis_tuser), s_axis_tdata[15:0],
                                                s_axis_tdata[79:16], s_axis_tdata[87:80]));
      end
      pending_o = awaited_resp_q.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the keyed record table: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import krt_pkg::*;

  localparam int STUCK_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BLOCKS = 23;
  localparam int BLOCK_ITEMS   = 50;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = KIND_INSERT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  int fail_count;
  int pending;
  int requests_sent = 0;
  int stuck_cycles  = 0;
  int source_mode   = 0;
  int sink_mode     = 0;
  bit held_off      = 1'b0;

  always #2 clk_i = ~clk_i;

  keyed_record_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  keyed_record_table_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Mode 0: never idle; mode 1: short gaps; mode 2: short gaps with some long ones.
  function automatic int pick_delay(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0:       return 0;
      1:       return (roll < 60) ? 0 : $urandom_range(1, 4);
      default: begin
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 6);
        return $urandom_range(20, 60);
      end
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] random_id();
    // Mostly a small pool so lookups, deletes and changes hit stored records.
    if ($urandom_range(0, 99) < 80) return KEY_W'($urandom_range(0, 23));
    return KEY_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [PRIO_W-1:0] random_prio();
    if ($urandom_range(0, 99) < 10) return PRIO_W'($urandom_range(0, 7));
    return PRIO_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [NAME_W-1:0] random_name();
    logic [NAME_W-1:0] raw;
    int                roll;
    int                len;
    roll = $urandom_range(0, 99);
    raw  = {$urandom, $urandom};
    if (roll < 20) return raw;
    if (roll < 50) begin
      // Short pool names (empty, "A".."G") to provoke name clashes.
      len = $urandom_range(0, 7);
      raw[7:0] = (len == 0) ? 8'h00 : 8'h40 + 8'(len);
      if (len != 0) raw[15:8] = 8'h00;
      if ($urandom_range(0, 1) == 0) raw[63:16] = '0;
      return raw;
    end
    len = $urandom_range(0, NAME_BYTES);
    for (int k = 0; k < len; k++) raw[8*k +: 8] = 8'($urandom_range(1, 255));
    if (len < NAME_BYTES) begin
      raw[8*len +: 8] = 8'h00;
      // Clear or keep the bytes after the terminator; both must compare the same.
      if ($urandom_range(0, 1) == 0) begin
        for (int k = len + 1; k < NAME_BYTES; k++) raw[8*k +: 8] = 8'h00;
      end
    end
    return raw;
  endfunction

  task automatic send_request(input kind_e kind, input logic [KEY_W-1:0] id,
                              input logic [NAME_W-1:0] raw_name,
                              input logic [PRIO_W-1:0] prio);
    int gap;
    gap = pick_delay(source_mode);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prio, raw_name, id};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  // Count cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : sink
    int hold;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 99) < 5) sink_mode = $urandom_range(0, 2);
      // Hold off once for a long stretch so the request side backs up.
      if (!held_off && requests_sent >= 60) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      hold = pick_delay(sink_mode);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin : source
    int    phase;
    int    roll;
    kind_e kind;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: field extremes, every clash, hits and misses of each kind.
    send_request(KIND_INSERT, 16'h0000, 64'h0, 8'h00);
    send_request(KIND_INSERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_request(KIND_INSERT, 16'h0000, 64'h0000_0000_0000_4D4D, 8'h05);
    // Empty name with junk after the leading zero byte
    send_request(KIND_INSERT, 16'h0007, 64'hFFFF_FFFF_FFFF_FF00, 8'h06);
    send_request(KIND_INSERT, 16'h0008, 64'h0000_0000_0000_4241, 8'h0A);
    // Same name once the junk after the terminator is dropped
    send_request(KIND_INSERT, 16'h0009, 64'h006B_6E75_6A00_4241, 8'h0B);
    send_request(KIND_INSERT, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    send_request(KIND_INSERT, 16'h0010, 64'h0000_0000_0000_4343, 8'hFF);
    send_request(KIND_LOOKUP, 16'h0000, 64'h0, 8'h00);
    send_request(KIND_LOOKUP, 16'hFFFF, 64'h0, 8'h00);
    send_request(KIND_LOOKUP, 16'h1234, 64'h0, 8'h00);
    // A changed priority may duplicate another record's priority.
    send_request(KIND_CHANGE, 16'h0008, 64'h0, 8'h00);
    send_request(KIND_LOOKUP, 16'h0008, 64'h0, 8'h00);
    send_request(KIND_CHANGE, 16'h4321, 64'h0, 8'h77);
    send_request(KIND_DELETE, 16'h0000, 64'h0, 8'h00);
    send_request(KIND_DELETE, 16'h0000, 64'h0, 8'h00);
    send_request(KIND_LOOKUP, 16'h0000, 64'h0, 8'h00);
    send_request(KIND_INSERT, 16'h0000, 64'h0, 8'h00);
    send_request(KIND_DELETE, 16'h0008, 64'h0, 8'h00);
    // Reuse of the lowest free slot
    send_request(KIND_INSERT, 16'h0000, 64'h0, 8'h00);
    send_request(KIND_LOOKUP, 16'h0000, 64'h0, 8'h00);

    // Random blocks alternate between filling the table, draining it and a mix.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      phase       = $urandom_range(0, 2);
      source_mode = $urandom_range(0, 2);
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        case (phase)
          0:       kind = (roll < 70) ? KIND_INSERT : (roll < 85) ? KIND_LOOKUP :
                          (roll < 90) ? KIND_DELETE : KIND_CHANGE;
          1:       kind = (roll < 20) ? KIND_INSERT : (roll < 40) ? KIND_LOOKUP :
                          (roll < 90) ? KIND_DELETE : KIND_CHANGE;
          default: kind = kind_e'(roll % 4);
        endcase
        send_request(kind, random_id(), random_name(), random_prio());
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker log the last request, then drain.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> keyed_record_table.f
+incdir+design
design/krt_pkg.sv
design/krt_ram.sv
design/krt_front.sv
design/krt_back.sv
design/keyed_record_table.sv
tb/sv/keyed_record_table_checker.sv
tb/sv/tb.sv
